/* rtl/core/hsp_pkg.sv */
// Shared types, constants and table builders for the hyperbolic squeeze point block.
package hsp_pkg;

    localparam int HYP_DEPTH       = 1024;
    localparam int TRIG_DEPTH      = 1024;
    localparam int COORD_FRAC_BITS = 14;

    localparam int COORD_W  = COORD_FRAC_BITS + 2;
    localparam int INT_W    = 15;
    localparam int ANG_W    = 13;
    localparam int RATIO_W  = 13;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int CTR_W = COORD_W + 1;
    localparam int DIF_W = COORD_W + 2;
    localparam int ROT_W = COORD_W + 3;
    localparam int TRN_W = COORD_W + 6;
    localparam int BCK_W = COORD_W + 7;
    localparam int SUM_W = COORD_W + 8;

    localparam int K_W   = INT_W + RATIO_W - 1;
    localparam int MAG_W = K_W - 1;
    localparam int HI_W  = $clog2(HYP_DEPTH + 1);
    localparam int HN_W  = MAG_W + HI_W + 1;
    localparam int HYP_SH = 25;

    localparam int TURN     = 5760;
    localparam int TN_W     = ANG_W + $clog2(TRIG_DEPTH + 1);
    localparam int RECIP_SH = 32;
    localparam int RECIP_W  = 20;
    localparam longint RECIP = (64'd1 << RECIP_SH) / TURN;
    localparam int QP_W     = TN_W + RECIP_W;
    localparam int Q_W      = $clog2(TRIG_DEPTH + 1);
    localparam int TI_W     = $clog2(TRIG_DEPTH);

    localparam int HYP_W    = 18;
    localparam int TRIG_W   = 18;
    localparam int TAB_FRAC = 16;

    localparam int INT_LIM   = 8192;
    localparam int RATIO_ONE = 4096;

    localparam int PIPE_DEPTH = 8;

    localparam longint unsigned Q28 = 64'd1 << 28;
    localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTENSITY = 2'd0,
        CFG_ANGLE     = 2'd1,
        CFG_CENTER_X  = 2'd2,
        CFG_CENTER_Y  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic        [RATIO_W-1:0] ratio;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      saturated;
    } t_rsp;

    typedef struct packed {
        logic signed [INT_W-1:0]   intensity;
        logic        [ANG_W-1:0]   angle;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
    } t_cfg;

    typedef struct packed {
        logic                      byp;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [CTR_W-1:0]   cx;
        logic signed [CTR_W-1:0]   cy;
        logic signed [DIF_W-1:0]   dx;
        logic signed [DIF_W-1:0]   dy;
    } t_geo;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic            ksign;
        logic [TI_W-1:0] ti;
        t_geo            geo;
    } t_idx;

    typedef struct packed {
        logic        [HYP_W-1:0]  ch;
        logic        [HYP_W-1:0]  sh;
        logic                     ksign;
        logic signed [TRIG_W-1:0] sa;
        logic signed [TRIG_W-1:0] ca;
    } t_coef;

    typedef logic        [HYP_W-1:0]  t_hyp_tab  [0:HYP_DEPTH];
    typedef logic signed [TRIG_W-1:0] t_trig_tab [0:TRIG_DEPTH-1];

    // unsigned quotient by shift and subtract, used by the table builders
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned part;
        quo  = '0;
        part = '0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[62:0], num[b]};
            if (part >= den) begin
                part   = part - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cosh/sinh of 2*i/HYP_DEPTH in Q.16
    function automatic t_hyp_tab build_hyp(input bit want_sinh);
        t_hyp_tab          tab;
        longint unsigned   x;
        longint unsigned   e;
        longint unsigned   t;
        longint unsigned   em;
        longint unsigned   v;
        for (int i = 0; i <= HYP_DEPTH; i++) begin
            x = (longint'(i) << 29) / HYP_DEPTH;
            e = Q28;
            t = Q28;
            for (int n = 1; n < 48; n++) begin
                t = udiv64((t * x) >> 28, 64'(n));
                if (t == 0) break;
                e = e + t;
            end
            em = udiv64((64'd1 << 56) + e / 2, e);
            if (want_sinh) v = (((e - em) / 2) + 2048) >> 12;
            else           v = (((e + em) / 2) + 2048) >> 12;
            tab[i] = v[HYP_W-1:0];
        end
        return tab;
    endfunction

    // sin/cos of i/TRIG_DEPTH turn in Q.16
    function automatic t_trig_tab build_trig(input bit want_cos);
        t_trig_tab         tab;
        longint unsigned   p;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   th;
        longint unsigned   t;
        longint            s;
        longint            c;
        longint            sv;
        longint            cv;
        for (int i = 0; i < TRIG_DEPTH; i++) begin
            p  = (longint'(i) << 32) / TRIG_DEPTH;
            q  = (p >> 30) & 64'd3;
            r  = p & ((64'd1 << 30) - 1);
            th = (r * TWO_PI_Q28) >> 32;
            t  = Q28;
            s  = 0;
            c  = longint'(Q28);
            for (int n = 1; n < 40; n++) begin
                t = udiv64((t * th) >> 28, 64'(n));
                if (t == 0) break;
                if (n % 2 == 1) begin
                    if ((n / 2) % 2 == 1) s = s - longint'(t);
                    else                  s = s + longint'(t);
                end else begin
                    if ((n / 2) % 2 == 1) c = c - longint'(t);
                    else                  c = c + longint'(t);
                end
            end
            s = (s + 2048) >>> 12;
            c = (c + 2048) >>> 12;
            if (s > 65536)  s = 65536;
            if (s < -65536) s = -65536;
            if (c > 65536)  c = 65536;
            if (c < -65536) c = -65536;
            case (q)
                64'd0:   begin sv = s;  cv = c;  end
                64'd1:   begin sv = c;  cv = -s; end
                64'd2:   begin sv = -s; cv = -c; end
                default: begin sv = -c; cv = s;  end
            endcase
            if (want_cos) tab[i] = cv[TRIG_W-1:0];
            else          tab[i] = sv[TRIG_W-1:0];
        end
        return tab;
    endfunction

endpackage

/* rtl/core/hyperbolic_squeeze_point.sv */
// Top level of the hyperbolic squeeze point transform.
//  channel  | valid        | ready        | payload
//  request  | i_req_valid  | o_req_ready  | i_req  (t_req)
//  result   | o_rsp_valid  | i_rsp_ready  | o_rsp  (t_rsp)
//  config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
// One request per cycle while the result side is not stalled.
// The pipeline has 8 stages: three index stages, table read,
// three multiply stages, recenter and saturate.
// A stall at the result side freezes every stage at once; no request is dropped.
// Reset clears the valid bits and the configuration registers.
module hyperbolic_squeeze_point (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  hsp_pkg::t_req                   i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output hsp_pkg::t_rsp                   o_rsp,
    input  logic                            i_cfg_we,
    input  logic [hsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hsp_pkg::CFG_W-1:0]       i_cfg_data
);
    import hsp_pkg::*;

    t_cfg r_cfg;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic  en;
    t_idx  idx;
    t_coef coef;
    t_geo  geo;

    assign en          = !r_vld[PIPE_DEPTH-1] || i_rsp_ready;
    assign o_req_ready = en;
    assign o_rsp_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_vld <= '0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_DEPTH-2:0], i_req_valid};
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_INTENSITY: r_cfg.intensity <= i_cfg_data[INT_W-1:0];
                    CFG_ANGLE:     r_cfg.angle     <= i_cfg_data[ANG_W-1:0];
                    CFG_CENTER_X:  r_cfg.center_x  <= i_cfg_data[COORD_W-1:0];
                    CFG_CENTER_Y:  r_cfg.center_y  <= i_cfg_data[COORD_W-1:0];
                endcase
            end
        end
    end

    hsp_index u_index (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (i_req),
        .i_cfg (r_cfg),
        .o_idx (idx)
    );

    hsp_tables u_tables (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_idx  (idx),
        .o_coef (coef),
        .o_geo  (geo)
    );

    hsp_xform u_xform (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_coef (coef),
        .i_geo  (geo),
        .o_rsp  (o_rsp)
    );

endmodule

/* rtl/core/hsp_index.sv */
// Front stages: strength, center, difference, hyperbolic and trig table indexes.
module hsp_index (
    input  logic         i_clk,
    input  logic         i_en,
    input  hsp_pkg::t_req i_req,
    input  hsp_pkg::t_cfg i_cfg,
    output hsp_pkg::t_idx o_idx
);
    import hsp_pkg::*;

    localparam logic signed [INT_W-1:0] INT_MAX = INT_W'(INT_LIM);
    localparam logic signed [INT_W-1:0] INT_MIN = -INT_W'(INT_LIM);
    localparam int HALF_TURN = TURN / 2;

    logic signed [INT_W-1:0]   int_c;
    logic        [RATIO_W-1:0] ratio_c;
    logic signed [K_W+1:0]     k_full;
    logic        [ANG_W-1:0]   ang_r;
    logic        [TN_W-1:0]    tnum;
    t_geo                      geo1;

    logic signed [K_W-1:0] r_k1;
    logic        [TN_W-1:0] r_tn1;
    t_geo                   r_geo1;

    logic [MAG_W-1:0]  mag;
    logic [HN_W-1:0]   hnum;
    logic [HN_W-HYP_SH-1:0] hi_raw;
    logic [HI_W-1:0]   hi2;
    logic [QP_W-1:0]   qprod;

    logic [HI_W-1:0]   r_hi2;
    logic              r_ks2;
    logic [Q_W-1:0]    r_q2;
    logic [TN_W-1:0]   r_tn2;
    t_geo              r_geo2;

    logic [TN_W:0]     rem;
    logic [Q_W-1:0]    q3;
    logic [Q_W-1:0]    qw;

    t_idx r_idx;

    always_comb begin
        int_c = i_cfg.intensity;
        if (i_cfg.intensity > INT_MAX)      int_c = INT_MAX;
        else if (i_cfg.intensity < INT_MIN) int_c = INT_MIN;
        ratio_c = (i_req.ratio > RATIO_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE) : i_req.ratio;
        k_full  = int_c * $signed({1'b0, ratio_c});
        ang_r   = (i_cfg.angle >= ANG_W'(TURN)) ? i_cfg.angle - ANG_W'(TURN) : i_cfg.angle;
        tnum    = TN_W'(ang_r) * TN_W'(TRIG_DEPTH) + TN_W'(HALF_TURN);
        geo1.byp = (i_cfg.intensity == '0) || (i_req.ratio == '0);
        geo1.px  = i_req.point_x;
        geo1.py  = i_req.point_y;
        geo1.cx  = CTR_W'(i_cfg.center_x) + CTR_W'(i_req.offset_x);
        geo1.cy  = CTR_W'(i_cfg.center_y) + CTR_W'(i_req.offset_y);
        geo1.dx  = DIF_W'(i_req.point_x) - DIF_W'(geo1.cx);
        geo1.dy  = DIF_W'(i_req.point_y) - DIF_W'(geo1.cy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k1   <= k_full[K_W-1:0];
            r_tn1  <= tnum;
            r_geo1 <= geo1;
        end
    end

    always_comb begin
        mag    = r_k1[K_W-1] ? MAG_W'(-r_k1) : MAG_W'(r_k1);
        hnum   = HN_W'(mag) * HN_W'(HYP_DEPTH) + (HN_W'(1) << (HYP_SH - 1));
        hi_raw = hnum[HN_W-1:HYP_SH];
        hi2    = (hi_raw > (HN_W-HYP_SH)'(HYP_DEPTH)) ? HI_W'(HYP_DEPTH) : HI_W'(hi_raw);
        qprod  = QP_W'(r_tn1) * QP_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi2  <= hi2;
            r_ks2  <= r_k1[K_W-1];
            r_q2   <= Q_W'(qprod[QP_W-1:RECIP_SH]);
            r_tn2  <= r_tn1;
            r_geo2 <= r_geo1;
        end
    end

    // one correction step after the reciprocal estimate
    always_comb begin
        rem = (TN_W+1)'(r_tn2) - (TN_W+1)'(r_q2) * (TN_W+1)'(TURN);
        q3  = (rem >= (TN_W+1)'(TURN)) ? r_q2 + Q_W'(1) : r_q2;
        qw  = (q3 >= Q_W'(TRIG_DEPTH)) ? q3 - Q_W'(TRIG_DEPTH) : q3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx.hi    <= r_hi2;
            r_idx.ksign <= r_ks2;
            r_idx.ti    <= TI_W'(qw);
            r_idx.geo   <= r_geo2;
        end
    end

    assign o_idx = r_idx;

endmodule

/* rtl/core/hsp_tables.sv */
// Registered cosh/sinh and sin/cos table reads.
module hsp_tables (
    input  logic           i_clk,
    input  logic           i_en,
    input  hsp_pkg::t_idx  i_idx,
    output hsp_pkg::t_coef o_coef,
    output hsp_pkg::t_geo  o_geo
);
    import hsp_pkg::*;

    localparam t_hyp_tab  COSH_TAB = build_hyp(1'b0);
    localparam t_hyp_tab  SINH_TAB = build_hyp(1'b1);
    localparam t_trig_tab SIN_TAB  = build_trig(1'b0);
    localparam t_trig_tab COS_TAB  = build_trig(1'b1);

    t_coef r_coef;
    t_geo  r_geo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef.ch    <= COSH_TAB[i_idx.hi];
            r_coef.sh    <= SINH_TAB[i_idx.hi];
            r_coef.ksign <= i_idx.ksign;
            r_coef.sa    <= SIN_TAB[i_idx.ti];
            r_coef.ca    <= COS_TAB[i_idx.ti];
            r_geo        <= i_idx.geo;
        end
    end

    assign o_coef = r_coef;
    assign o_geo  = r_geo;

endmodule

/* rtl/core/hsp_xform.sv */
// Rotate, hyperbolic map, rotate back, recenter and saturate, or pass the point through on bypass.
module hsp_xform (
    input  logic           i_clk,
    input  logic           i_en,
    input  hsp_pkg::t_coef i_coef,
    input  hsp_pkg::t_geo  i_geo,
    output hsp_pkg::t_rsp  o_rsp
);
    import hsp_pkg::*;

    localparam int P5_W = DIF_W + TRIG_W + 1;
    localparam int P6_W = ROT_W + HYP_W + 2;
    localparam int P7_W = TRN_W + TRIG_W + 1;
    localparam int RND  = 1 << (TAB_FRAC - 1);
    localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] C_MIN = -SUM_W'(1 << (COORD_W - 1));

    logic signed [P5_W-1:0] p5x, p5y;
    logic signed [HYP_W:0]  shs;
    logic signed [ROT_W-1:0] r_rx, r_ry;
    logic signed [HYP_W:0]  r_ch5, r_sh5;
    logic signed [TRIG_W-1:0] r_sa5, r_ca5, r_sa6, r_ca6;
    t_geo r_geo5, r_geo6, r_geo7;

    logic signed [P6_W-1:0] p6x, p6y;
    logic signed [TRN_W-1:0] r_tx, r_ty;

    logic signed [P7_W-1:0] p7x, p7y;
    logic signed [BCK_W-1:0] r_nx, r_ny;

    logic signed [SUM_W-1:0] sx, sy;
    t_rsp rsp8, r_rsp;

    always_comb begin
        p5x = i_geo.dx * i_coef.ca - i_geo.dy * i_coef.sa + P5_W'(RND);
        p5y = i_geo.dx * i_coef.sa + i_geo.dy * i_coef.ca + P5_W'(RND);
        shs = i_coef.ksign ? -$signed({1'b0, i_coef.sh}) : $signed({1'b0, i_coef.sh});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx   <= p5x[TAB_FRAC +: ROT_W];
            r_ry   <= p5y[TAB_FRAC +: ROT_W];
            r_ch5  <= $signed({1'b0, i_coef.ch});
            r_sh5  <= shs;
            r_sa5  <= i_coef.sa;
            r_ca5  <= i_coef.ca;
            r_geo5 <= i_geo;
        end
    end

    always_comb begin
        p6x = r_rx * r_ch5 + r_ry * r_sh5 + P6_W'(RND);
        p6y = r_rx * r_sh5 + r_ry * r_ch5 + P6_W'(RND);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx   <= p6x[TAB_FRAC +: TRN_W];
            r_ty   <= p6y[TAB_FRAC +: TRN_W];
            r_sa6  <= r_sa5;
            r_ca6  <= r_ca5;
            r_geo6 <= r_geo5;
        end
    end

    always_comb begin
        p7x = r_tx * r_ca6 + r_ty * r_sa6 + P7_W'(RND);
        p7y = r_ty * r_ca6 - r_tx * r_sa6 + P7_W'(RND);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx   <= p7x[TAB_FRAC +: BCK_W];
            r_ny   <= p7y[TAB_FRAC +: BCK_W];
            r_geo7 <= r_geo6;
        end
    end

    always_comb begin
        sx = SUM_W'(r_geo7.cx) + SUM_W'(r_nx);
        sy = SUM_W'(r_geo7.cy) + SUM_W'(r_ny);
        rsp8.saturated = 1'b0;
        if (sx > C_MAX) begin
            rsp8.out_x = COORD_W'(C_MAX);
            rsp8.saturated = 1'b1;
        end else if (sx < C_MIN) begin
            rsp8.out_x = COORD_W'(C_MIN);
            rsp8.saturated = 1'b1;
        end else begin
            rsp8.out_x = COORD_W'(sx);
        end
        if (sy > C_MAX) begin
            rsp8.out_y = COORD_W'(C_MAX);
            rsp8.saturated = 1'b1;
        end else if (sy < C_MIN) begin
            rsp8.out_y = COORD_W'(C_MIN);
            rsp8.saturated = 1'b1;
        end else begin
            rsp8.out_y = COORD_W'(sy);
        end
        if (r_geo7.byp) begin
            rsp8.out_x = r_geo7.px;
            rsp8.out_y = r_geo7.py;
            rsp8.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= rsp8;
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* rtl/core/hsp_checker.sv */
// Port-level checks for the hyperbolic squeeze point block, with bind.
module hsp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          o_req_ready,
    input hsp_pkg::t_req                 i_req,
    input logic                          o_rsp_valid,
    input logic                          i_rsp_ready,
    input hsp_pkg::t_rsp                 o_rsp,
    input logic                          i_cfg_we,
    input logic [hsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [hsp_pkg::CFG_W-1:0]     i_cfg_data
);
    import hsp_pkg::*;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready == (!o_rsp_valid || i_rsp_ready))
        else $error("request ready not tied to result drain");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.saturated |->
            o_rsp.out_x == C_MAX || o_rsp.out_x == C_MIN ||
            o_rsp.out_y == C_MAX || o_rsp.out_y == C_MIN)
        else $error("saturated flag without clipped coordinate");

endmodule

bind hyperbolic_squeeze_point hsp_checker u_hsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data)
);

/* sim/tb.sv */
// Self-checking testbench for the hyperbolic squeeze point transform.
`timescale 1ns / 1ps

module tb;
    import hsp_pkg::*;

    class squeeze_scoreboard;
        logic signed [INT_W-1:0]   intensity;
        logic        [ANG_W-1:0]   angle;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        longint cosh_q16 [0:HYP_DEPTH];
        longint sinh_q16 [0:HYP_DEPTH];
        longint sin_q16 [0:TRIG_DEPTH-1];
        longint cos_q16 [0:TRIG_DEPTH-1];
        t_rsp   pending[$];
        int     errors;
        int     checked;
        int     sat_seen;
        int     bypass_seen;

        function new();
            longint unsigned x, e, t, em, p, r, th;
            longint s, c;
            int q;
            intensity = '0;
            angle = '0;
            center_x = '0;
            center_y = '0;
            errors = 0;
            checked = 0;
            sat_seen = 0;
            bypass_seen = 0;
            for (int i = 0; i <= HYP_DEPTH; i++) begin
                x = (longint'(i) << 29) / HYP_DEPTH;
                e = 64'd1 << 28;
                t = 64'd1 << 28;
                for (int n = 1; n < 48; n++) begin
                    t = ((t * x) >> 28) / longint'(n);
                    if (t == 0) break;
                    e += t;
                end
                em = ((64'd1 << 56) + e / 2) / e;
                cosh_q16[i] = longint'((((e + em) / 2) + 2048) >> 12);
                sinh_q16[i] = longint'((((e - em) / 2) + 2048) >> 12);
            end
            for (int i = 0; i < TRIG_DEPTH; i++) begin
                p  = (longint'(i) << 32) / TRIG_DEPTH;
                q  = int'((p >> 30) & 3);
                r  = p & ((64'd1 << 30) - 1);
                th = (r * 64'd1686629713) >> 32;
                t  = 64'd1 << 28;
                s  = 0;
                c  = longint'(64'd1 << 28);
                for (int n = 1; n < 40; n++) begin
                    t = ((t * th) >> 28) / longint'(n);
                    if (t == 0) break;
                    if (n % 2 == 1) s = ((n / 2) % 2 == 1) ? s - longint'(t) : s + longint'(t);
                    else            c = ((n / 2) % 2 == 1) ? c - longint'(t) : c + longint'(t);
                end
                s = (s + 2048) >>> 12;
                c = (c + 2048) >>> 12;
                if (s > 65536) s = 65536;
                if (s < -65536) s = -65536;
                if (c > 65536) c = 65536;
                if (c < -65536) c = -65536;
                case (q)
                    0:       begin sin_q16[i] = s;  cos_q16[i] = c;  end
                    1:       begin sin_q16[i] = c;  cos_q16[i] = -s; end
                    2:       begin sin_q16[i] = -s; cos_q16[i] = -c; end
                    default: begin sin_q16[i] = -c; cos_q16[i] = s;  end
                endcase
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_INTENSITY: intensity = data[INT_W-1:0];
                CFG_ANGLE:     angle = data[ANG_W-1:0];
                CFG_CENTER_X:  center_x = data;
                default:       center_y = data;
            endcase
        endfunction

        function longint round16(longint v);
            return (v + 32768) >>> 16;
        endfunction

        function longint clip_coord(longint v, ref bit sat);
            if (v > 32767) begin sat = 1; return 32767; end
            if (v < -32768) begin sat = 1; return -32768; end
            return v;
        endfunction

        function void note_request(t_req rq);
            t_rsp   rs;
            longint inten, ratio, k, mag, hi, ch, sh, a, ti, sa, ca;
            longint cx, cy, dx, dy, rx, ry, tx, ty, nx, ny;
            bit     sat;
            inten = intensity;
            ratio = rq.ratio;
            sat = 0;
            if (inten == 0 || ratio == 0) begin
                rs.out_x = rq.point_x;
                rs.out_y = rq.point_y;
                rs.saturated = 1'b0;
                bypass_seen++;
            end else begin
                if (inten > INT_LIM) inten = INT_LIM;
                if (inten < -INT_LIM) inten = -INT_LIM;
                if (ratio > RATIO_ONE) ratio = RATIO_ONE;
                k = inten * ratio;
                mag = k < 0 ? -k : k;
                hi = (mag * HYP_DEPTH + (64'sd1 << 24)) >>> 25;
                if (hi > HYP_DEPTH) hi = HYP_DEPTH;
                ch = cosh_q16[hi];
                sh = k < 0 ? -sinh_q16[hi] : sinh_q16[hi];
                a = longint'(angle) % TURN;
                ti = (a * TRIG_DEPTH + TURN / 2) / TURN;
                if (ti >= TRIG_DEPTH) ti -= TRIG_DEPTH;
                sa = sin_q16[ti];
                ca = cos_q16[ti];
                cx = longint'(center_x) + longint'(rq.offset_x);
                cy = longint'(center_y) + longint'(rq.offset_y);
                dx = longint'(rq.point_x) - cx;
                dy = longint'(rq.point_y) - cy;
                rx = round16(dx * ca - dy * sa);
                ry = round16(dx * sa + dy * ca);
                tx = round16(rx * ch + ry * sh);
                ty = round16(rx * sh + ry * ch);
                nx = round16(tx * ca + ty * sa);
                ny = round16(ty * ca - tx * sa);
                rs.out_x = COORD_W'(clip_coord(cx + nx, sat));
                rs.out_y = COORD_W'(clip_coord(cy + ny, sat));
                rs.saturated = sat;
                if (sat) sat_seen++;
            end
            pending.push_back(rs);
        endfunction

        function void check_result(t_rsp got);
            t_rsp exp_rsp;
            if (pending.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", got.out_x, got.out_y);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            checked++;
            if (got.out_x !== exp_rsp.out_x) begin
                $error("out_x expected %0d actual %0d", exp_rsp.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== exp_rsp.out_y) begin
                $error("out_y expected %0d actual %0d", exp_rsp.out_y, got.out_y);
                errors++;
            end
            if (got.saturated !== exp_rsp.saturated) begin
                $error("saturated expected %0b actual %0b", exp_rsp.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_req_valid;
    logic                 o_req_ready;
    t_req                 i_req;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready = 1'b0;
    t_rsp                 o_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    squeeze_scoreboard sb = new();
    int  send_idle_pct = 33;
    int  recv_idle_pct = 33;
    bit  hold_off_go;
    int  hold_count = 0;
    int  cycles = 0;
    int  sent;

    hyperbolic_squeeze_point u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && o_req_ready) sb.note_request(i_req);
        if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_result(o_rsp);
    end

    // receiver: random backpressure, plus one long hold-off on demand
    always @(posedge i_clk) begin
        if (hold_off_go && hold_count < 80) begin
            hold_count <= hold_count + 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= rq;
        sent++;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] inten, logic [CFG_W-1:0] ang,
                              logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy);
        drain();
        write_reg(CFG_INTENSITY, inten);
        write_reg(CFG_ANGLE, ang);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
    endtask

    function automatic t_req make_request(int mode);
        t_req rq;
        rq.point_x = $urandom;
        rq.point_y = $urandom;
        rq.offset_x = $urandom;
        rq.offset_y = $urandom;
        rq.ratio = $urandom;
        if (mode == 0) begin
            rq.point_x = $urandom_range(16383) - 8192;
            rq.point_y = $urandom_range(16383) - 8192;
            rq.offset_x = $urandom_range(8191) - 4096;
            rq.offset_y = $urandom_range(8191) - 4096;
            rq.ratio = $urandom_range(RATIO_ONE);
        end else if (mode == 1) begin
            rq.offset_x = $urandom_range(32768) - 16384;
            rq.offset_y = $urandom_range(32768) - 16384;
            rq.ratio = $urandom_range(RATIO_ONE);
        end
        return rq;
    endfunction

    function automatic t_req pack_req(int px, int py, int ratio, int ox, int oy);
        t_req rq;
        rq.point_x = px;
        rq.point_y = py;
        rq.ratio = ratio;
        rq.offset_x = ox;
        rq.offset_y = oy;
        return rq;
    endfunction

    initial begin
        int phase_int[8];
        int phase_ang[8];
        sent = 0;
        hold_off_go = 1'b0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_INTENSITY;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: zero strength passes points through
        send_request(pack_req(32767, -32768, 4096, 0, 0));
        send_request(pack_req(-32768, 32767, 8191, -16384, 16384));
        set_config(16'd8192, 16'd0, 16'd0, 16'd0);
        send_request(pack_req(1000, -2000, 0, 0, 0));
        send_request(pack_req(4096, 4096, 4096, 0, 0));
        send_request(pack_req(-4096, 2048, 8191, 0, 0));
        send_request(pack_req(32767, 32767, 4096, 16384, 16384));
        send_request(pack_req(-32768, -32768, 4096, -16384, -16384));
        send_request(pack_req(16384, 0, 1, 0, 0));
        send_request(pack_req(0, 0, 4096, 0, 0));
        set_config(16'h3FFF, 16'd5759, 16'd16384, -16'sd16384);
        send_request(pack_req(8000, -8000, 4096, 0, 0));
        send_request(pack_req(-32768, 32767, 2048, 16384, -16384));
        send_request(pack_req(100, 200, 8191, -16384, 16384));
        set_config(16'h4000, 16'd8191, -16'sd16384, 16'd16384);
        send_request(pack_req(3000, -5000, 4096, 0, 0));
        send_request(pack_req(32767, -32768, 1024, 0, 0));
        send_request(pack_req(-1, 1, 4096, -16384, -16384));
        set_config(-16'sd8192, 16'd1440, 16'd0, 16'd0);
        send_request(pack_req(8192, 8192, 4096, 0, 0));
        send_request(pack_req(8192, -8192, 4096, 0, 0));
        set_config(16'h7FFF, 16'd2880, 16'd100, -16'sd100);
        send_request(pack_req(8192, 0, 4096, 0, 0));

        phase_int = '{0, 8192, -8192, 1, 16383, 4096, -3000, 12000};
        phase_ang = '{0, 5759, 8191, 720, 0, 5760, 3000, 4000};
        for (int ph = 0; ph < 8; ph++) begin
            set_config(ph < 4 ? phase_int[ph] : $urandom_range(32767) - 16384,
                       ph == 7 ? $urandom_range(8191) : phase_ang[ph],
                       ph == 1 ? 16'd16384 : $urandom_range(32768) - 16384,
                       ph == 2 ? -16'sd16384 : $urandom_range(32768) - 16384);
            if (ph == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 33;
                recv_idle_pct = 33;
            end
            if (ph == 5) begin
                send_idle_pct = 0;
                hold_off_go <= 1'b1;
            end
            for (int n = 0; n < 80; n++) begin
                int r;
                r = $urandom_range(99);
                send_request(make_request(r < 60 ? 0 : (r < 85 ? 1 : 2)));
            end
            hold_off_go <= 1'b0;
        end

        drain();
        $display("Checked %0d results from %0d requests; %0d bypassed, %0d saturated.",
                 sb.checked, sent, sb.bypass_seen, sb.sat_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

/* files.f */
rtl/core/hsp_pkg.sv
rtl/core/hsp_index.sv
rtl/core/hsp_tables.sv
rtl/core/hsp_xform.sv
rtl/core/hyperbolic_squeeze_point.sv
rtl/core/hsp_checker.sv
sim/tb.sv
